FILE: design/kci_pkg.sv
// package: shared types and constants of the keyframe curve interpolator
`timescale 1ns / 1ps
package kci_pkg;
    localparam int MAX_KEYS_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QDEPTH        = 2;

    localparam logic [15:0] REM_TOL_RST = 16'd66;
    localparam logic [15:0] HAS_TOL_RST = 16'd7;

    typedef enum logic [1:0] {
        OP_EVAL   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    localparam logic CFG_REM_TOL = 1'b0;
    localparam logic CFG_HAS_TOL = 1'b1;

    typedef struct packed {
        t_op         op;
        logic [31:0] t;
        logic [31:0] v;
        logic [15:0] tol;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_EV_RD,
        S_EV_DIV,
        S_EV_MUL,
        S_EV_ADD,
        S_DONE
    } t_state;
endpackage

FILE: design/kci_front.sv
// front part: accepts items, picks the tolerance, and queues commands
`timescale 1ns / 1ps
module kci_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_opcode,
    input  logic [31:0]   i_key_time,
    input  logic [31:0]   i_key_value,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_pop,
    output logic          o_busy,
    output logic          o_valid,
    output kci_pkg::t_cmd o_cmd
);
    logic [15:0] r_rem_tol;
    logic [15:0] r_has_tol;
    kci_pkg::t_cmd r_q [kci_pkg::QDEPTH];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;
    logic w_push;
    kci_pkg::t_cmd w_cmd;

    assign o_busy  = (r_cnt == 2'(kci_pkg::QDEPTH));
    assign w_push  = i_start && !o_busy;
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_comb begin
        w_cmd.op  = kci_pkg::t_op'(i_opcode);
        w_cmd.t   = i_key_time;
        w_cmd.v   = i_key_value;
        w_cmd.tol = (kci_pkg::t_op'(i_opcode) == kci_pkg::OP_REMOVE) ? r_rem_tol : r_has_tol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem_tol <= kci_pkg::REM_TOL_RST;
            r_has_tol <= kci_pkg::HAS_TOL_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == kci_pkg::CFG_REM_TOL) r_rem_tol <= i_cfg_data;
            else r_has_tol <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(kci_pkg::QDEPTH)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop of empty queue");
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(kci_pkg::QDEPTH)) |-> o_busy) else $error("full queue not busy");
endmodule

FILE: design/kci_div.sv
// serial restoring divider for the interpolation fraction
`timescale 1ns / 1ps
module kci_div #(
    parameter int FRAC_BITS = kci_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [32:0]          i_num,
    input  logic [32:0]          i_den,
    output logic                 o_done,
    output logic [FRAC_BITS:0]   o_quot
);
    localparam int NB = 33 + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    logic [NB-1:0] r_n;
    logic [33:0]   r_rem;
    logic [32:0]   r_den;
    logic [CW-1:0] r_i;
    logic          r_run;
    logic [33:0]   w_try;
    logic [34:0]   w_diff;

    assign w_try  = {r_rem[32:0], r_n[NB-1]};
    assign w_diff = {1'b0, w_try} - {2'b0, r_den};
    assign o_quot = r_n[FRAC_BITS:0];
    assign o_done = r_run && (r_i == CW'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_i   <= '0;
        end else if (i_go) begin
            r_n   <= {i_num, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
            r_i   <= CW'(NB);
            r_run <= 1'b1;
        end else if (r_run) begin
            if (r_i == CW'(0)) begin
                r_run <= 1'b0;
            end else begin
                r_i <= r_i - CW'(1);
                if (!w_diff[34]) begin
                    r_rem <= w_diff[33:0];
                    r_n   <= {r_n[NB-2:0], 1'b1};
                end else begin
                    r_rem <= w_try;
                    r_n   <= {r_n[NB-2:0], 1'b0};
                end
            end
        end
    end
endmodule

FILE: design/kci_back.sv
// back part: key table, search, shift and interpolation sequencer
`timescale 1ns / 1ps
module kci_back #(
    parameter int MAX_KEYS  = kci_pkg::MAX_KEYS_DEF,
    parameter int FRAC_BITS = kci_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  kci_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_strobe,
    output logic [31:0]   o_result_value,
    output logic [1:0]    o_status,
    output logic [$clog2(MAX_KEYS+1)-1:0] o_key_count
);
    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic [31:0] r_kt [MAX_KEYS];
    logic [31:0] r_kv [MAX_KEYS];
    logic [31:0] r_rt;
    logic [31:0] r_rv;

    kci_pkg::t_state r_st, n_st;
    kci_pkg::t_cmd r_c;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_pos, n_pos;
    logic [AW-1:0] w_ra;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [31:0]   w_wt, w_wv;
    logic [31:0]   r_t1, n_t1, r_v1, n_v1;
    logic [31:0]   r_res, n_res;
    logic [1:0]    r_stat, n_stat;
    logic          r_go, n_go;
    logic [32:0]   w_num, w_den;
    logic          w_ddone;
    logic [FRAC_BITS:0] w_q;
    logic [31:0]   r_prod;
    logic [32:0]   w_dist;
    logic [32:0]   w_ad;
    logic signed [32:0] w_dv;
    logic signed [FRAC_BITS+1:0] w_al;
    logic signed [FRAC_BITS+34:0] w_mul;

    // table read port, registered
    always_ff @(posedge i_clk) begin
        r_rt <= r_kt[w_ra];
        r_rv <= r_kv[w_ra];
        if (w_we) begin
            r_kt[w_wa] <= w_wt;
            r_kv[w_wa] <= w_wv;
        end
    end

    kci_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_go),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_ddone),
        .o_quot (w_q)
    );

    assign w_num = {r_c.t[31], r_c.t} - {r_t1[31], r_t1};
    assign w_den = {r_rt[31], r_rt} - {r_t1[31], r_t1};
    assign w_ad  = {r_rt[31], r_rt} - {r_c.t[31], r_c.t};
    assign w_dist = w_ad[32] ? (33'd0 - w_ad) : w_ad;
    // product (v2 - v1) * alpha
    assign w_dv  = $signed({r_rv[31], r_rv}) - $signed({r_v1[31], r_v1});
    assign w_al  = $signed({1'b0, w_q});
    assign w_mul = w_dv * w_al;

    always_ff @(posedge i_clk) begin
        if (r_st == kci_pkg::S_EV_MUL) r_prod <= 32'(w_mul >>> FRAC_BITS);
    end

    always_comb begin
        n_st   = r_st;
        n_cnt  = r_cnt;
        n_i    = r_i;
        n_pos  = r_pos;
        n_t1   = r_t1;
        n_v1   = r_v1;
        n_res  = r_res;
        n_stat = r_stat;
        n_go   = 1'b0;
        o_pop  = 1'b0;
        w_ra   = r_i[AW-1:0];
        w_we   = 1'b0;
        w_wa   = r_i[AW-1:0];
        w_wt   = r_c.t;
        w_wv   = r_c.v;
        case (r_st)
            kci_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_pop  = 1'b1;
                    n_i    = '0;
                    w_ra   = '0;
                    n_res  = '0;
                    n_stat = kci_pkg::ST_OK;
                    n_pos  = r_cnt;
                    if (i_cmd.op == kci_pkg::OP_INSERT && r_cnt == CW'(MAX_KEYS)) begin
                        n_stat = kci_pkg::ST_FULL;
                        n_st   = kci_pkg::S_DONE;
                    end else if (i_cmd.op == kci_pkg::OP_EVAL && r_cnt == '0) begin
                        n_stat = kci_pkg::ST_EMPTY;
                        n_st   = kci_pkg::S_DONE;
                    end else begin
                        n_st = kci_pkg::S_SCAN;
                    end
                end
            end
            kci_pkg::S_SCAN: begin
                // r_rt/r_rv hold entry r_i
                w_ra = AW'(r_i + CW'(1));
                n_i  = r_i + CW'(1);
                if (r_i == r_cnt) begin
                    if (r_c.op == kci_pkg::OP_INSERT) begin
                        n_i = r_cnt; n_st = kci_pkg::S_SHIFT;
                        w_ra = AW'(r_cnt - CW'(1));
                    end else if (r_c.op == kci_pkg::OP_EVAL) begin
                        n_res = r_v1; n_st = kci_pkg::S_DONE;
                    end else begin
                        n_stat = kci_pkg::ST_NOTFOUND; n_st = kci_pkg::S_DONE;
                    end
                end else begin
                    case (r_c.op)
                        kci_pkg::OP_INSERT: begin
                            if ($signed(r_rt) > $signed(r_c.t)) begin
                                n_pos = r_i; n_i = r_cnt; n_st = kci_pkg::S_SHIFT;
                                w_ra = AW'(r_cnt - CW'(1));
                            end
                        end
                        kci_pkg::OP_EVAL: begin
                            if (r_i == '0) begin
                                if ($signed(r_c.t) <= $signed(r_rt)) begin
                                    n_res = r_rv; n_st = kci_pkg::S_DONE;
                                end else begin
                                    n_t1 = r_rt; n_v1 = r_rv;
                                end
                            end else if (r_t1 == r_c.t) begin
                                // equal-time run: first key wins, the last one at table end
                                if (r_rt == r_c.t) begin
                                    n_t1 = r_rt; n_v1 = r_rv;
                                end else begin
                                    n_st = kci_pkg::S_DONE;
                                end
                            end else if (r_rt == r_c.t) begin
                                n_res = r_rv; n_t1 = r_rt; n_v1 = r_rv;
                            end else if ($signed(r_c.t) < $signed(r_rt)) begin
                                if (r_rt == r_t1) begin
                                    n_res = r_v1; n_st = kci_pkg::S_DONE;
                                end else begin
                                    // segment end stays on the read port during the division
                                    n_i  = r_i;
                                    w_ra = r_i[AW-1:0];
                                    n_go = 1'b1; n_st = kci_pkg::S_EV_DIV;
                                end
                            end else begin
                                n_t1 = r_rt; n_v1 = r_rv;
                            end
                        end
                        kci_pkg::OP_REMOVE: begin
                            if (w_dist < {17'd0, r_c.tol}) begin
                                n_cnt = r_cnt - CW'(1);
                                n_i   = r_i + CW'(1);
                                n_st  = kci_pkg::S_SHIFT;
                            end
                        end
                        default: begin
                            if (w_dist < {17'd0, r_c.tol}) n_st = kci_pkg::S_DONE;
                        end
                    endcase
                end
            end
            kci_pkg::S_SHIFT: begin
                // r_rt/r_rv hold the entry just read
                if (r_c.op == kci_pkg::OP_INSERT) begin
                    if (r_i == r_pos) begin
                        w_we = 1'b1; w_wa = r_pos[AW-1:0];
                        n_cnt = r_cnt + CW'(1); n_st = kci_pkg::S_DONE;
                    end else begin
                        w_we = 1'b1; w_wa = r_i[AW-1:0];
                        w_wt = r_rt; w_wv = r_rv;
                        n_i  = r_i - CW'(1);
                        w_ra = AW'(r_i - CW'(2));
                    end
                end else begin
                    // remove: r_rt holds entry r_i, write to r_i-1
                    if (r_i > r_cnt) begin
                        n_st = kci_pkg::S_DONE;
                    end else begin
                        w_we = 1'b1; w_wa = AW'(r_i - CW'(1));
                        w_wt = r_rt; w_wv = r_rv;
                        n_i  = r_i + CW'(1);
                        w_ra = AW'(r_i + CW'(1));
                    end
                end
            end
            kci_pkg::S_EV_DIV: begin
                if (w_ddone) n_st = kci_pkg::S_EV_MUL;
            end
            kci_pkg::S_EV_MUL: n_st = kci_pkg::S_EV_ADD;
            kci_pkg::S_EV_ADD: begin
                n_res = r_v1 + r_prod;
                n_st  = kci_pkg::S_DONE;
            end
            kci_pkg::S_DONE: n_st = kci_pkg::S_IDLE;
            default: n_st = kci_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= kci_pkg::S_IDLE;
            r_cnt <= '0;
            r_go  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
            r_go  <= n_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_c <= i_cmd;
        r_i    <= n_i;
        r_pos  <= n_pos;
        r_t1   <= n_t1;
        r_v1   <= n_v1;
        r_res  <= n_res;
        r_stat <= n_stat;
    end

    assign o_strobe       = (r_st == kci_pkg::S_DONE);
    assign o_result_value = r_res;
    assign o_status       = r_stat;
    assign o_key_count    = r_cnt;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_KEYS)) else $error("key count out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_st == kci_pkg::S_IDLE)) else $error("pop while busy");
    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("double strobe");
endmodule

FILE: design/keyframe_curve_interpolator_unit.sv
// top level of the keyframe curve interpolator
`timescale 1ns / 1ps
// Items enter through a two-entry command queue and are carried out one at a time.
// Insert and remove scan to the key, then shift each moved key via the table read and
// write ports; query scans the table for a key within the tolerance; evaluate scans to
// the segment and runs a serial divider of 33 + FRAC_BITS steps. Each item gives one
// result strobe of one cycle; results cannot be held off.
module keyframe_curve_interpolator_unit #(
    parameter int MAX_KEYS  = kci_pkg::MAX_KEYS_DEF,
    parameter int FRAC_BITS = kci_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_key_time,
    input  logic [31:0] i_key_value,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic [31:0] o_result_value,
    output logic [1:0]  o_status,
    output logic [$clog2(MAX_KEYS+1)-1:0] o_key_count
);
    logic          w_valid;
    logic          w_pop;
    kci_pkg::t_cmd w_cmd;

    kci_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_opcode   (i_opcode),
        .i_key_time (i_key_time),
        .i_key_value(i_key_value),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pop      (w_pop),
        .o_busy     (busy),
        .o_valid    (w_valid),
        .o_cmd      (w_cmd)
    );

    kci_back #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_valid),
        .i_cmd         (w_cmd),
        .o_pop         (w_pop),
        .o_strobe      (o_strobe),
        .o_result_value(o_result_value),
        .o_status      (o_status),
        .o_key_count   (o_key_count)
    );
endmodule

FILE: sim/testbench.sv
// testbench for the keyframe curve interpolator: directed and random items, scoreboard check
`timescale 1ns / 1ps
class kci_scoreboard;
    logic signed [31:0] times[$];
    logic signed [31:0] values[$];
    logic [15:0] rem_tol;
    logic [15:0] has_tol;
    logic [31:0] exp_value[$];
    logic [1:0]  exp_status[$];
    logic [4:0]  exp_count[$];
    int errors;
    int checked;

    function void init();
        times.delete();
        values.delete();
        rem_tol = kci_pkg::REM_TOL_RST;
        has_tol = kci_pkg::HAS_TOL_RST;
        errors = 0;
        checked = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] data);
        if (idx == kci_pkg::CFG_REM_TOL) rem_tol = data;
        else has_tol = data;
    endfunction

    function int nearest(logic signed [31:0] t, logic [15:0] tol);
        longint d;
        for (int i = 0; i < times.size(); i++) begin
            d = longint'(times[i]) - longint'(t);
            if (d < 0) d = -d;
            if (d < longint'(tol)) return i;
        end
        return -1;
    endfunction

    function logic signed [31:0] interpolate(logic signed [31:0] t);
        int last;
        longint span, alpha, dv, prod;
        last = times.size() - 1;
        if (t <= times[0]) return values[0];
        if (t >= times[last]) return values[last];
        for (int i = 0; i < last; i++) begin
            if (times[i] <= t && t <= times[i+1]) begin
                if (times[i] == times[i+1]) return values[i];
                span = longint'(times[i+1]) - longint'(times[i]);
                alpha = ((longint'(t) - longint'(times[i])) <<< 16) / span;
                dv = longint'(values[i+1]) - longint'(values[i]);
                prod = dv * alpha;
                return 32'(longint'(values[i]) + (prod >>> 16));
            end
        end
        return 0;
    endfunction

    function void note_item(kci_pkg::t_op op, logic signed [31:0] t, logic signed [31:0] v);
        logic [31:0] res;
        kci_pkg::t_status st;
        int pos;
        res = 0;
        st = kci_pkg::ST_OK;
        case (op)
            kci_pkg::OP_EVAL: begin
                if (times.size() == 0) st = kci_pkg::ST_EMPTY;
                else res = interpolate(t);
            end
            kci_pkg::OP_INSERT: begin
                if (times.size() >= kci_pkg::MAX_KEYS_DEF) st = kci_pkg::ST_FULL;
                else begin
                    pos = 0;
                    while (pos < times.size() && times[pos] <= t) pos++;
                    times.insert(pos, t);
                    values.insert(pos, v);
                end
            end
            kci_pkg::OP_REMOVE: begin
                pos = nearest(t, rem_tol);
                if (pos >= 0) begin
                    times.delete(pos);
                    values.delete(pos);
                end else st = kci_pkg::ST_NOTFOUND;
            end
            default: begin
                if (nearest(t, has_tol) < 0) st = kci_pkg::ST_NOTFOUND;
            end
        endcase
        exp_value.push_back(res);
        exp_status.push_back(st);
        exp_count.push_back(5'(times.size()));
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic check_result(logic [31:0] val, logic [1:0] st, logic [4:0] cnt);
        checked++;
        if (exp_value.size() == 0) begin
            report("unexpected result", val, 32'd0);
            return;
        end
        if (val !== exp_value[0]) report("result_value", val, exp_value[0]);
        if (st !== exp_status[0]) report("status", 32'(st), 32'(exp_status[0]));
        if (cnt !== exp_count[0]) report("key_count", 32'(cnt), 32'(exp_count[0]));
        void'(exp_value.pop_front());
        void'(exp_status.pop_front());
        void'(exp_count.pop_front());
    endtask
endclass

module testbench;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic [1:0]  i_opcode = 0;
    logic [31:0] i_key_time = 0;
    logic [31:0] i_key_value = 0;
    logic        i_cfg_we = 0;
    logic        i_cfg_idx = 0;
    logic [15:0] i_cfg_data = 0;
    logic        o_strobe;
    logic [31:0] o_result_value;
    logic [1:0]  o_status;
    logic [4:0]  o_key_count;

    kci_scoreboard sb;
    int cycles = 0;
    int items = 0;
    logic signed [31:0] anchor[$];

    keyframe_curve_interpolator_unit dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_strobe) sb.check_result(o_result_value, o_status, o_key_count);
    end

    task automatic send_item(kci_pkg::t_op op, logic [31:0] t, logic [31:0] v);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            start <= 0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1;
        i_opcode <= op;
        i_key_time <= t;
        i_key_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_item(op, t, v);
        items++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        start <= 0;
        while (sb.exp_value.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, data);
    endtask

    function automatic logic [31:0] pick_time();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0 || anchor.size() == 0) return $urandom;
        if (r < 4) return anchor[$urandom_range(0, anchor.size() - 1)];
        return anchor[$urandom_range(0, anchor.size() - 1)] + $urandom_range(0, 200) - 100;
    endfunction

    task automatic random_phase(int n);
        int r;
        logic [31:0] t;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 9);
            t = pick_time();
            if (r < 4) send_item(kci_pkg::OP_EVAL, t, 0);
            else if (r < 7) begin
                if ($urandom_range(0, 1)) t = $urandom_range(0, 64) << $urandom_range(0, 24);
                if ($urandom_range(0, 7) == 0) t = $urandom;
                anchor.push_back(t);
                send_item(kci_pkg::OP_INSERT, t, $urandom);
            end else if (r < 9) send_item(kci_pkg::OP_REMOVE, t, $urandom);
            else send_item(kci_pkg::OP_QUERY, t, $urandom);
        end
    endtask

    initial begin
        sb = new();
        sb.init();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // empty table cases
        send_item(kci_pkg::OP_EVAL, 32'h0, 32'h0);
        send_item(kci_pkg::OP_REMOVE, 32'h0, 32'h0);
        send_item(kci_pkg::OP_QUERY, 32'h0, 32'h0);
        send_item(kci_pkg::OP_INSERT, 32'h8000_0000, 32'h7fff_ffff);
        send_item(kci_pkg::OP_INSERT, 32'h7fff_ffff, 32'h8000_0000);
        send_item(kci_pkg::OP_EVAL, 32'h0000_0001, 32'hffff_ffff);
        send_item(kci_pkg::OP_EVAL, 32'h8000_0000, 32'h0);
        send_item(kci_pkg::OP_EVAL, 32'h7fff_ffff, 32'h0);
        // equal times and a zero span segment
        send_item(kci_pkg::OP_INSERT, 32'h0001_0000, 32'h0000_1000);
        send_item(kci_pkg::OP_INSERT, 32'h0001_0000, 32'hffff_0000);
        send_item(kci_pkg::OP_EVAL, 32'h0001_0000, 32'h0);
        send_item(kci_pkg::OP_EVAL, 32'h0000_8000, 32'h0);
        send_item(kci_pkg::OP_QUERY, 32'h0001_0006, 32'h0);
        send_item(kci_pkg::OP_QUERY, 32'h0001_0007, 32'h0);
        send_item(kci_pkg::OP_REMOVE, 32'h0001_0041, 32'h0);
        send_item(kci_pkg::OP_REMOVE, 32'h0001_0042, 32'h0);
        // fill to full
        for (int k = 0; k < 14; k++) send_item(kci_pkg::OP_INSERT, $urandom, $urandom);
        send_item(kci_pkg::OP_INSERT, 32'h0, 32'h0);
        send_item(kci_pkg::OP_EVAL, $urandom, 32'h0);
        write_reg(kci_pkg::CFG_REM_TOL, 16'hffff);
        write_reg(kci_pkg::CFG_HAS_TOL, 16'h0);
        send_item(kci_pkg::OP_QUERY, 32'h7fff_ffff, 32'h0);
        while (sb.times.size() > 0)
            send_item(kci_pkg::OP_REMOVE, sb.times[0] ^ 32'h1, 32'h0);
        random_phase(250);
        write_reg(kci_pkg::CFG_REM_TOL, 16'h0);
        write_reg(kci_pkg::CFG_HAS_TOL, 16'hffff);
        random_phase(250);
        write_reg(kci_pkg::CFG_REM_TOL, 16'($urandom_range(1, 300)));
        write_reg(kci_pkg::CFG_HAS_TOL, 16'($urandom_range(1, 300)));
        random_phase(250);
        start <= 0;
        while (sb.exp_value.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("ran %0d items, checked %0d results through three tolerance settings",
                 items, sb.checked);
        if (sb.errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
